### rtl/core/obbc_pkg.sv
// shared constants, types and tables for the oriented box to ball contact block
package obbc_pkg;

  localparam int CFG_W   = 20;
  localparam int POS_W   = 24;
  localparam int HEAD_W  = 16;
  localparam int OUT_W   = 26;
  localparam int DELTA_W = POS_W + 1;
  localparam int FWD_W   = 28;
  localparam int EX_W    = 27;
  localparam int NEAR_W  = 21;
  localparam int REACH_W = 22;
  localparam int NSQ_W   = 2 * REACH_W;
  localparam int SQ_W    = 2 * FWD_W;
  localparam int DIST_W  = SQ_W / 2;
  localparam int IDX_W   = 3;
  localparam int ATAN_LEN = 24;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam longint GAIN_Q30 = 64'd652032874;

  localparam logic [CFG_W-1:0] FRONT_RST = 20'd19661;
  localparam logic [CFG_W-1:0] REAR_RST  = 20'd19661;
  localparam logic [CFG_W-1:0] HALF_RST  = 20'd9830;
  localparam logic [CFG_W-1:0] RADIUS_RST = 20'd7209;
  localparam logic [CFG_W-1:0] TOL_RST   = 20'd1311;

  typedef enum logic [IDX_W-1:0] {
    REG_FRONT  = 3'd0,
    REG_REAR   = 3'd1,
    REG_HALF   = 3'd2,
    REG_RADIUS = 3'd3,
    REG_TOL    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [FWD_W-1:0] fwd;
    logic signed [FWD_W-1:0] lat;
    logic                    front_pre;
    logic                    rear_pre;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  typedef struct packed {
    logic [CFG_W-1:0] front_extent;
    logic [CFG_W-1:0] rear_extent;
    logic [CFG_W-1:0] half_width;
    logic [CFG_W-1:0] ball_radius;
    logic [CFG_W-1:0] contact_tolerance;
  } cfg_t;

  // arctangent of 2^-i in 32-bit binary angle
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    unique case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

### rtl/core/obbc_pose_if.sv
// input channel: robot pose and ball centre
interface obbc_pose_if;
  logic                                valid;
  logic                                ready;
  logic signed [obbc_pkg::POS_W-1:0]   robot_pos_x;
  logic signed [obbc_pkg::POS_W-1:0]   robot_pos_y;
  logic        [obbc_pkg::HEAD_W-1:0]  robot_heading;
  logic signed [obbc_pkg::POS_W-1:0]   ball_pos_x;
  logic signed [obbc_pkg::POS_W-1:0]   ball_pos_y;

  modport source (output valid, robot_pos_x, robot_pos_y, robot_heading, ball_pos_x,
                  ball_pos_y, input ready);
  modport sink (input valid, robot_pos_x, robot_pos_y, robot_heading, ball_pos_x,
                ball_pos_y, output ready);
endinterface

### rtl/core/obbc_contact_if.sv
// output channel: contact result
interface obbc_contact_if;
  logic                              valid;
  logic                              ready;
  logic                              valid_res;
  logic signed [obbc_pkg::OUT_W-1:0] forward_offset;
  logic signed [obbc_pkg::OUT_W-1:0] lateral_offset;
  logic signed [obbc_pkg::OUT_W-1:0] separation;
  logic                              intersects;
  logic                              front_touch;
  logic                              rear_touch;
  logic                              side_touch;

  modport source (output valid, valid_res, forward_offset, lateral_offset, separation,
                  intersects, front_touch, rear_touch, side_touch, input ready);
  modport sink (input valid, valid_res, forward_offset, lateral_offset, separation,
                intersects, front_touch, rear_touch, side_touch, output ready);
endinterface

### rtl/core/obbc_cordic.sv
// pipelined rotation-mode cordic, one iteration per stage
module obbc_cordic #(
  parameter int STEPS  = obbc_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC   = obbc_pkg::FRACTION_BITS_DEF,
  parameter int SIDE_W = 2 * obbc_pkg::DELTA_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            ce,
  input  logic                            in_valid,
  input  logic [obbc_pkg::HEAD_W-1:0]     heading,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            out_valid,
  output logic signed [FRAC+2:0]          cos_raw,
  output logic signed [FRAC+2:0]          sin_raw,
  output logic                            flip,
  output logic [SIDE_W-1:0]               side_out
);
  localparam int W = FRAC + 3;
  localparam int Z_W = 33;
  localparam longint GAIN_INIT =
    (obbc_pkg::GAIN_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC);

  logic signed [W-1:0]   xr [0:STEPS];
  logic signed [W-1:0]   yr [0:STEPS];
  logic signed [Z_W-1:0] zr [0:STEPS];
  logic                  fr [0:STEPS];
  logic                  vr [0:STEPS];
  logic [SIDE_W-1:0]     sr [0:STEPS];

  logic [31:0] ang;
  logic        ang_flip;
  logic [31:0] ang_fold;

  // fold the back half-turn onto the front half and negate at the end
  assign ang      = {heading, 16'h0000};
  assign ang_flip = ang[31] ^ ang[30];
  assign ang_fold = ang_flip ? {~ang[31], ang[30:0]} : ang;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (ce) begin
      vr[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      xr[0] <= W'(GAIN_INIT);
      yr[0] <= '0;
      zr[0] <= Z_W'($signed(ang_fold));
      fr[0] <= ang_flip;
      sr[0] <= side_in;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    logic signed [Z_W-1:0] atan_k;
    assign atan_k = $signed({1'b0, obbc_pkg::atan_turn(k)});

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k+1] <= 1'b0;
      end else if (ce) begin
        vr[k+1] <= vr[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        if (!zr[k][Z_W-1]) begin
          xr[k+1] <= xr[k] - (yr[k] >>> k);
          yr[k+1] <= yr[k] + (xr[k] >>> k);
          zr[k+1] <= zr[k] - atan_k;
        end else begin
          xr[k+1] <= xr[k] + (yr[k] >>> k);
          yr[k+1] <= yr[k] - (xr[k] >>> k);
          zr[k+1] <= zr[k] + atan_k;
        end
        fr[k+1] <= fr[k];
        sr[k+1] <= sr[k];
      end
    end
  end

  assign out_valid = vr[STEPS];
  assign cos_raw   = xr[STEPS];
  assign sin_raw   = yr[STEPS];
  assign flip      = fr[STEPS];
  assign side_out  = sr[STEPS];

endmodule

### rtl/core/obbc_frame.sv
// rotation into the robot frame, box clamp, squared distances and face tests
module obbc_frame #(
  parameter int FRAC = obbc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  ce,
  input  logic                                  in_valid,
  input  logic signed [FRAC+2:0]                cos_raw,
  input  logic signed [FRAC+2:0]                sin_raw,
  input  logic                                  flip,
  input  logic signed [obbc_pkg::DELTA_W-1:0]   dx,
  input  logic signed [obbc_pkg::DELTA_W-1:0]   dy,
  input  obbc_pkg::cfg_t                        cfg,
  output logic                                  out_valid,
  output logic [obbc_pkg::SQ_W-1:0]             sum_sq,
  output obbc_pkg::side_t                       side
);
  localparam int W   = FRAC + 3;
  localparam int P_W = W + obbc_pkg::DELTA_W;
  localparam int S_W = P_W + 1;
  localparam int C_W = 30;
  localparam int FW  = obbc_pkg::FWD_W;
  localparam int EW  = obbc_pkg::EX_W;
  localparam int NW  = obbc_pkg::NEAR_W;

  logic [4:0] v;

  // reach squared, refreshed every cycle from the registers
  logic [obbc_pkg::REACH_W-1:0] reach1;
  logic [obbc_pkg::NSQ_W-1:0]   reach_sq;
  assign reach1 = obbc_pkg::REACH_W'(cfg.ball_radius) +
                  obbc_pkg::REACH_W'(cfg.contact_tolerance) + 1'b1;
  always_ff @(posedge clk) begin
    reach_sq <= reach1 * reach1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[3:0], in_valid};
    end
  end

  // stage 1: products
  logic signed [W-1:0]   c_n, s_n;
  logic signed [P_W-1:0] cdx, sdy, cdy, sdx;
  assign c_n = flip ? -cos_raw : cos_raw;
  assign s_n = flip ? -sin_raw : sin_raw;
  always_ff @(posedge clk) begin
    if (ce) begin
      cdx <= c_n * dx;
      sdy <= s_n * dy;
      cdy <= c_n * dy;
      sdx <= s_n * dx;
    end
  end

  // stage 2: rounded offsets
  localparam logic signed [S_W-1:0] RND = S_W'(1) <<< (FRAC - 1);
  logic signed [S_W-1:0] fsum, lsum;
  logic signed [FW-1:0]  fwd2, lat2;
  assign fsum = S_W'(cdx) + S_W'(sdy) + RND;
  assign lsum = S_W'(cdy) - S_W'(sdx) + RND;
  always_ff @(posedge clk) begin
    if (ce) begin
      fwd2 <= fsum[FRAC+FW-1:FRAC];
      lat2 <= lsum[FRAC+FW-1:FRAC];
    end
  end

  // stage 3: clamp to the box and near-face guards
  logic signed [C_W-1:0] fwd_w, lat_w, fe_w, re_w, hw_w, tol_w, reach_w;
  logic signed [C_W-1:0] hi_d, lo_d, lat_abs, le_raw, le_w, ex_w, ey_w, fa_w, ra_w;
  logic                  fg, rg;
  logic [EW-1:0]         ex3, ey3;
  logic [NW-1:0]         fa3, ra3, la3;
  logic                  fg3, rg3;
  logic signed [FW-1:0]  fwd3, lat3;

  always_comb begin
    fwd_w   = C_W'(fwd2);
    lat_w   = C_W'(lat2);
    fe_w    = C_W'(cfg.front_extent);
    re_w    = C_W'(cfg.rear_extent);
    hw_w    = C_W'(cfg.half_width);
    tol_w   = C_W'(cfg.contact_tolerance);
    reach_w = C_W'(cfg.ball_radius) + tol_w;
    hi_d    = fwd_w - fe_w;
    lo_d    = fwd_w + re_w;
    lat_abs = lat_w[C_W-1] ? -lat_w : lat_w;
    le_raw  = lat_abs - hw_w;
    le_w    = (le_raw > 0) ? le_raw : '0;
    ex_w    = (hi_d > 0) ? hi_d : ((lo_d < 0) ? -lo_d : '0);
    ey_w    = le_w;
    fa_w    = hi_d[C_W-1] ? -hi_d : hi_d;
    ra_w    = lo_d[C_W-1] ? -lo_d : lo_d;
    fg      = (fwd_w >= fe_w - tol_w) && (fa_w <= reach_w) && (le_w <= reach_w);
    rg      = (fwd_w <= tol_w - re_w) && (ra_w <= reach_w) && (le_w <= reach_w);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ex3  <= ex_w[EW-1:0];
      ey3  <= ey_w[EW-1:0];
      fa3  <= fa_w[NW-1:0];
      ra3  <= ra_w[NW-1:0];
      la3  <= le_w[NW-1:0];
      fg3  <= fg;
      rg3  <= rg;
      fwd3 <= fwd2;
      lat3 <= lat2;
    end
  end

  // stage 4: squares
  logic [2*EW-1:0]      sx4, sy4;
  logic [2*NW-1:0]      sf4, sr4, sl4;
  logic                 fg4, rg4;
  logic signed [FW-1:0] fwd4, lat4;
  always_ff @(posedge clk) begin
    if (ce) begin
      sx4  <= ex3 * ex3;
      sy4  <= ey3 * ey3;
      sf4  <= fa3 * fa3;
      sr4  <= ra3 * ra3;
      sl4  <= la3 * la3;
      fg4  <= fg3;
      rg4  <= rg3;
      fwd4 <= fwd3;
      lat4 <= lat3;
    end
  end

  // stage 5: sums and face compares
  logic [obbc_pkg::NSQ_W-1:0] fsq, rsq;
  assign fsq = obbc_pkg::NSQ_W'(sf4) + obbc_pkg::NSQ_W'(sl4);
  assign rsq = obbc_pkg::NSQ_W'(sr4) + obbc_pkg::NSQ_W'(sl4);
  always_ff @(posedge clk) begin
    if (ce) begin
      sum_sq         <= obbc_pkg::SQ_W'(sx4) + obbc_pkg::SQ_W'(sy4);
      side.fwd       <= fwd4;
      side.lat       <= lat4;
      side.front_pre <= fg4 && (fsq < reach_sq);
      side.rear_pre  <= rg4 && (rsq < reach_sq);
    end
  end

  assign out_valid = v[4];

endmodule

### rtl/core/obbc_isqrt.sv
// pipelined floored integer square root, one result bit per stage
module obbc_isqrt #(
  parameter int IN_W   = obbc_pkg::SQ_W,
  parameter int SIDE_W = obbc_pkg::SIDE_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ce,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       radicand,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [IN_W/2-1:0]     root,
  output logic [SIDE_W-1:0]     side_out
);
  localparam int R = IN_W / 2;

  logic [IN_W-1:0]   qr [0:R];
  logic [IN_W-1:0]   rr [0:R];
  logic              vr [0:R];
  logic [SIDE_W-1:0] sr [0:R];

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (ce) begin
      vr[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      qr[0] <= radicand;
      rr[0] <= '0;
      sr[0] <= side_in;
    end
  end

  for (genvar m = 0; m < R; m++) begin : g_bit
    localparam logic [IN_W-1:0] BIT = IN_W'(1) << (2 * (R - 1 - m));
    logic [IN_W-1:0] trial;
    assign trial = rr[m] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[m+1] <= 1'b0;
      end else if (ce) begin
        vr[m+1] <= vr[m];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        if (qr[m] >= trial) begin
          qr[m+1] <= qr[m] - trial;
          rr[m+1] <= (rr[m] >> 1) + BIT;
        end else begin
          qr[m+1] <= qr[m];
          rr[m+1] <= rr[m] >> 1;
        end
        sr[m+1] <= sr[m];
      end
    end
  end

  assign out_valid = vr[R];
  assign root      = rr[R][R-1:0];
  assign side_out  = sr[R];

endmodule

### rtl/core/oriented_box_ball_contact.sv
// top level: oriented box to ball contact pipeline
// Takes one pose beat per cycle (robot x, y, heading and ball x, y) and returns
// one contact beat per pose, in order. At the default widths an accepted pose beat
// passes through the cordic load register (written at the accepting edge), one
// cordic stage per rotation step, five frame stages (products, rounding, clamp,
// squares, sums), the square root load register and its 28 bit stages, and the
// output register before its result beat appears at the output. Throughput is one
// beat per cycle; a stall on the output freezes the whole pipeline, so pose.ready
// follows contact.ready whenever a result is waiting. Registers are written through
// cfg_we/cfg_idx/cfg_wdata and must only change while the pipeline is empty; a zero
// extent, half width or radius yields an all-zero result with valid_res low.
module oriented_box_ball_contact #(
  parameter int CORDIC_STEPS  = obbc_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = obbc_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [obbc_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [obbc_pkg::CFG_W-1:0]    cfg_wdata,
  obbc_pose_if.sink                     pose,
  obbc_contact_if.source                contact
);
  localparam int W      = FRACTION_BITS + 3;
  localparam int DW     = obbc_pkg::DELTA_W;
  localparam int E_W    = 30;
  localparam int OUT_W  = obbc_pkg::OUT_W;

  // configuration registers
  obbc_pkg::cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.front_extent      <= obbc_pkg::FRONT_RST;
      cfg.rear_extent       <= obbc_pkg::REAR_RST;
      cfg.half_width        <= obbc_pkg::HALF_RST;
      cfg.ball_radius       <= obbc_pkg::RADIUS_RST;
      cfg.contact_tolerance <= obbc_pkg::TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        obbc_pkg::REG_FRONT:  cfg.front_extent      <= cfg_wdata;
        obbc_pkg::REG_REAR:   cfg.rear_extent       <= cfg_wdata;
        obbc_pkg::REG_HALF:   cfg.half_width        <= cfg_wdata;
        obbc_pkg::REG_RADIUS: cfg.ball_radius       <= cfg_wdata;
        obbc_pkg::REG_TOL:    cfg.contact_tolerance <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a finished beat is held
  logic ce;
  assign ce         = !contact.valid || contact.ready;
  assign pose.ready = ce;

  // ball offset in the world frame, carried alongside the cordic
  logic signed [DW-1:0] dx_in, dy_in;
  assign dx_in = DW'(pose.ball_pos_x) - DW'(pose.robot_pos_x);
  assign dy_in = DW'(pose.ball_pos_y) - DW'(pose.robot_pos_y);

  logic                   cor_valid, cor_flip;
  logic signed [W-1:0]    cor_cos, cor_sin;
  logic [2*DW-1:0]        cor_side;

  obbc_cordic #(
    .STEPS  (CORDIC_STEPS),
    .FRAC   (FRACTION_BITS),
    .SIDE_W (2 * DW)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (pose.valid),
    .heading   (pose.robot_heading),
    .side_in   ({dx_in, dy_in}),
    .out_valid (cor_valid),
    .cos_raw   (cor_cos),
    .sin_raw   (cor_sin),
    .flip      (cor_flip),
    .side_out  (cor_side)
  );

  // rotation into robot frame, clamp, squared distances
  logic                          frm_valid;
  logic [obbc_pkg::SQ_W-1:0]     frm_sq;
  obbc_pkg::side_t               frm_side;

  obbc_frame #(
    .FRAC (FRACTION_BITS)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (cor_valid),
    .cos_raw   (cor_cos),
    .sin_raw   (cor_sin),
    .flip      (cor_flip),
    .dx        ($signed(cor_side[2*DW-1:DW])),
    .dy        ($signed(cor_side[DW-1:0])),
    .cfg       (cfg),
    .out_valid (frm_valid),
    .sum_sq    (frm_sq),
    .side      (frm_side)
  );

  // distance from the box surface to the ball centre
  logic                          sq_valid;
  logic [obbc_pkg::DIST_W-1:0]   root_len;
  logic [obbc_pkg::SIDE_W-1:0]   sq_side_bits;
  obbc_pkg::side_t               sq_side;

  obbc_isqrt #(
    .IN_W   (obbc_pkg::SQ_W),
    .SIDE_W (obbc_pkg::SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (frm_valid),
    .radicand  (frm_sq),
    .side_in   (frm_side),
    .out_valid (sq_valid),
    .root      (root_len),
    .side_out  (sq_side_bits)
  );
  assign sq_side = obbc_pkg::side_t'(sq_side_bits);

  // final decision: separation, flags, saturation and config gating
  logic                   cfg_ok;
  logic signed [E_W-1:0]  sep_w, tol_w, fwd_w, lat_w;
  logic                   inter, front, rear, side_c;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [E_W-1:0] val);
    logic signed [E_W-1:0] hi, lo;
    hi = E_W'((longint'(1) <<< (OUT_W - 1)) - 1);
    lo = -E_W'(longint'(1) <<< (OUT_W - 1));
    if (val > hi) begin
      return hi[OUT_W-1:0];
    end else if (val < lo) begin
      return lo[OUT_W-1:0];
    end
    return val[OUT_W-1:0];
  endfunction

  always_comb begin
    cfg_ok = (cfg.front_extent != '0) && (cfg.rear_extent != '0) &&
             (cfg.half_width != '0) && (cfg.ball_radius != '0);
    sep_w  = E_W'(root_len) - E_W'(cfg.ball_radius);
    tol_w  = E_W'(cfg.contact_tolerance);
    fwd_w  = E_W'(sq_side.fwd);
    lat_w  = E_W'(sq_side.lat);
    inter  = sep_w <= tol_w;
    front  = inter && sq_side.front_pre;
    rear   = inter && !front && sq_side.rear_pre;
    side_c = inter && !front && !rear;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      contact.valid <= 1'b0;
    end else if (ce) begin
      contact.valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      contact.valid_res      <= cfg_ok;
      contact.forward_offset <= cfg_ok ? sat_out(fwd_w) : '0;
      contact.lateral_offset <= cfg_ok ? sat_out(lat_w) : '0;
      contact.separation     <= cfg_ok ? sat_out(sep_w) : '0;
      contact.intersects     <= cfg_ok && inter;
      contact.front_touch    <= cfg_ok && front;
      contact.rear_touch     <= cfg_ok && rear;
      contact.side_touch     <= cfg_ok && side_c;
    end
  end

  // contact faces are exclusive
  assert property (@(posedge clk) disable iff (rst)
    contact.valid |-> $onehot0({contact.front_touch, contact.rear_touch,
                                contact.side_touch}))
    else $error("more than one contact face flagged");

  // any face contact implies intersection
  assert property (@(posedge clk) disable iff (rst)
    contact.valid && (contact.front_touch || contact.rear_touch ||
                      contact.side_touch) |-> contact.intersects)
    else $error("face contact without intersection");

  // unusable configuration must give a cleared result
  assert property (@(posedge clk) disable iff (rst)
    contact.valid && !contact.valid_res |->
      (contact.forward_offset == '0) && (contact.separation == '0) && !contact.intersects)
    else $error("result not cleared under unusable configuration");

  // a held result stays put while the sink stalls
  assert property (@(posedge clk) disable iff (rst)
    contact.valid && !contact.ready |=> contact.valid && $stable(contact.separation))
    else $error("stalled result changed");

endmodule
